// ===== src/i2cee_pkg.sv =====
// Package for the I2C EEPROM byte access master: sequence phases, step kinds,
// line masks and the per-tick sequencer state record.
// No dependencies.
`timescale 1ns / 1ps

package i2cee_pkg;

   localparam int ARRAY_BYTES = 2048;
   localparam logic [10:0] ADDR_MASK = 11'(ARRAY_BYTES - 1);

   localparam logic [15:0] WRITE_CYCLE_RESET = 16'd400;

   localparam logic [7:0] DEV_BASE   = 8'hA0;
   localparam logic [7:0] DEV_WR_AND = 8'hFE;
   localparam logic [7:0] DEV_RD_OR  = 8'h01;
   localparam logic [3:0] READ_BITS  = 4'd8;
   localparam logic [3:0] REC_PULSES = 4'd9;

   localparam int LN_SCL = 0;
   localparam int LN_SDA = 1;
   localparam int LN_WP  = 2;

   typedef enum logic [1:0] {
      OP_NONE    = 2'd0,
      OP_READ    = 2'd1,
      OP_WRITE   = 2'd2,
      OP_RECOVER = 2'd3
   } op_type;

   localparam logic [4:0] PH_IDLE    = 5'd0;
   localparam logic [4:0] PH_WRITE   = 5'd1;
   localparam logic [4:0] PH_WR_LAST = 5'd11;
   localparam logic [4:0] PH_READ    = 5'd12;
   localparam logic [4:0] PH_RD_LAST = 5'd22;
   localparam logic [4:0] PH_RECOVER = 5'd23;
   localparam logic [4:0] PH_REC_END = 5'd25;

   typedef enum logic [14:0] {
      K_IDLE     = 15'b000000000000001,
      K_WPLOW    = 15'b000000000000010,
      K_WPHIGH   = 15'b000000000000100,
      K_START    = 15'b000000000001000,
      K_STOP     = 15'b000000000010000,
      K_WR_DEVW  = 15'b000000000100000,
      K_WR_DEVR  = 15'b000000001000000,
      K_WR_WORD  = 15'b000000010000000,
      K_WR_DATA  = 15'b000000100000000,
      K_ACK      = 15'b000001000000000,
      K_RD       = 15'b000010000000000,
      K_WAIT     = 15'b000100000000000,
      K_REC_INIT = 15'b001000000000000,
      K_REC_LOOP = 15'b010000000000000,
      K_REC_TAIL = 15'b100000000000000
   } kind_type;

   typedef struct packed {
      logic [4:0]  phase;
      logic [3:0]  bit_index;
      logic [7:0]  shift_byte;
      logic [15:0] wait_count;
      logic [7:0]  captured;
      logic [10:0] address;
      logic [7:0]  data;
      logic [2:0]  lines;
   } seq_type;

   function automatic kind_type phase_kind(input logic [4:0] p);
      kind_type k;
      case (p)
         5'd1:    k = K_WPLOW;
         5'd2:    k = K_START;
         5'd3:    k = K_WR_DEVW;
         5'd4:    k = K_ACK;
         5'd5:    k = K_WR_WORD;
         5'd6:    k = K_ACK;
         5'd7:    k = K_WR_DATA;
         5'd8:    k = K_ACK;
         5'd9:    k = K_STOP;
         5'd10:   k = K_WAIT;
         5'd11:   k = K_WPHIGH;
         5'd12:   k = K_START;
         5'd13:   k = K_WR_DEVW;
         5'd14:   k = K_ACK;
         5'd15:   k = K_WR_WORD;
         5'd16:   k = K_ACK;
         5'd17:   k = K_START;
         5'd18:   k = K_WR_DEVR;
         5'd19:   k = K_ACK;
         5'd20:   k = K_RD;
         5'd21:   k = K_ACK;
         5'd22:   k = K_STOP;
         5'd23:   k = K_REC_INIT;
         5'd24:   k = K_REC_LOOP;
         5'd25:   k = K_REC_TAIL;
         default: k = K_IDLE;
      endcase
      return k;
   endfunction

   function automatic logic phase_last(input logic [4:0] p);
      return (p == PH_WR_LAST) || (p == PH_RD_LAST) || (p == PH_REC_END);
   endfunction

endpackage

// ===== src/i2c_eeprom_byte_access_master_core.sv =====
// Top level of the I2C EEPROM byte access master: one bus tick per request
// transfer, sequencer step and result register. Depends on i2cee_pkg.
`timescale 1ns / 1ps
// The response for a tick is registered and appears in the cycle after its request transfer.
// One tick per cycle while responses are taken; the sequencer step is a single pass of logic.
// The request side stays ready while the held response is being taken.
// Reset (synchronous, active high): sequencer idle, lines scl/sda high, write
// protect set, read byte zero, write cycle length 400 ticks, no response held.

module i2c_eeprom_byte_access_master_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // address[10:0], write_data[18:11], sda_in[19], zero
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // scl[0], sda_drive[1], write_protect[2], busy_res[3],
                                    // done_res[4], read_data[12:5], zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata    // write_cycle_ticks
);

   typedef struct packed {
      i2cee_pkg::seq_type nxt;
      logic               busy;
      logic               done;
   } step_type;

   i2cee_pkg::seq_type seq_ff, seq_in;
   logic [15:0]        wct_ff, wct_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_data_ff, rsp_data_in;
   step_type           step;
   logic               req_fire;

   function automatic i2cee_pkg::seq_type enter_phase(input i2cee_pkg::seq_type s_i,
                                                      input logic [4:0] p,
                                                      input logic [15:0] wct);
      i2cee_pkg::seq_type s;
      logic [7:0]         dev;
      s = s_i;
      dev = i2cee_pkg::DEV_BASE | {4'b0, s.address[10:8], 1'b0};
      s.phase = p;
      s.bit_index = '0;
      s.wait_count = '0;
      case (i2cee_pkg::phase_kind(p))
         i2cee_pkg::K_WR_DEVW: s.shift_byte = dev & i2cee_pkg::DEV_WR_AND;
         i2cee_pkg::K_WR_DEVR: s.shift_byte = dev | i2cee_pkg::DEV_RD_OR;
         i2cee_pkg::K_WR_WORD: s.shift_byte = s.address[7:0];
         i2cee_pkg::K_WR_DATA: s.shift_byte = s.data;
         i2cee_pkg::K_RD:      s.shift_byte = '0;
         i2cee_pkg::K_WAIT: begin
            s.wait_count = wct;
            if (wct == '0) begin
               s.phase = 5'(p + 5'd1);
            end
         end
         default: ;
      endcase
      return s;
   endfunction

   function automatic step_type run_step(input i2cee_pkg::seq_type s_i,
                                         input logic [1:0] op,
                                         input logic [10:0] addr,
                                         input logic [7:0] wdata,
                                         input logic sda,
                                         input logic [15:0] wct);
      step_type           o;
      i2cee_pkg::seq_type s;
      logic [1:0]         r;
      s = s_i;
      r = 2'd0;
      o.busy = 1'b0;
      o.done = 1'b0;
      if (i2cee_pkg::phase_kind(s.phase) == i2cee_pkg::K_IDLE) begin
         s.phase = i2cee_pkg::PH_IDLE;
         if (op != i2cee_pkg::OP_NONE) begin
            s.address = addr & i2cee_pkg::ADDR_MASK;
            s.data = wdata;
            case (op)
               i2cee_pkg::OP_READ:  s = enter_phase(s, i2cee_pkg::PH_READ, wct);
               i2cee_pkg::OP_WRITE: s = enter_phase(s, i2cee_pkg::PH_WRITE, wct);
               default:             s = enter_phase(s, i2cee_pkg::PH_RECOVER, wct);
            endcase
         end
      end
      if (s.phase != i2cee_pkg::PH_IDLE) begin
         o.busy = 1'b1;
         unique case (i2cee_pkg::phase_kind(s.phase))
            i2cee_pkg::K_WPLOW: begin
               s.lines[i2cee_pkg::LN_WP] = 1'b0;
               r = 2'd1;
            end
            i2cee_pkg::K_WPHIGH: begin
               s.lines[i2cee_pkg::LN_WP] = 1'b1;
               r = 2'd1;
            end
            i2cee_pkg::K_START: begin
               if (s.wait_count == '0) begin
                  s.lines[i2cee_pkg::LN_SDA] = 1'b1;
                  s.lines[i2cee_pkg::LN_SCL] = 1'b1;
                  s.wait_count = 16'd1;
               end else begin
                  s.lines[i2cee_pkg::LN_SDA] = 1'b0;
                  r = 2'd1;
               end
            end
            i2cee_pkg::K_STOP: begin
               if (s.wait_count == '0) begin
                  s.lines[i2cee_pkg::LN_SDA] = 1'b0;
                  s.lines[i2cee_pkg::LN_SCL] = 1'b1;
                  s.wait_count = 16'd1;
               end else begin
                  s.lines[i2cee_pkg::LN_SDA] = 1'b1;
                  r = 2'd1;
               end
            end
            i2cee_pkg::K_WR_DEVW, i2cee_pkg::K_WR_DEVR,
            i2cee_pkg::K_WR_WORD, i2cee_pkg::K_WR_DATA: begin
               if (s.bit_index >= i2cee_pkg::READ_BITS) begin
                  s.lines[i2cee_pkg::LN_SCL] = 1'b0;
                  s.lines[i2cee_pkg::LN_SDA] = 1'b1;
                  r = 2'd1;
               end else if (s.wait_count == 16'd0) begin
                  s.lines[i2cee_pkg::LN_SCL] = 1'b0;
                  s.wait_count = 16'd1;
               end else if (s.wait_count == 16'd1) begin
                  s.lines[i2cee_pkg::LN_SDA] = s.shift_byte[7];
                  s.wait_count = 16'd2;
               end else begin
                  s.lines[i2cee_pkg::LN_SCL] = 1'b1;
                  s.shift_byte = {s.shift_byte[6:0], 1'b0};
                  s.bit_index = 4'(s.bit_index + 4'd1);
                  s.wait_count = 16'd0;
               end
            end
            i2cee_pkg::K_ACK: begin
               if (s.wait_count == '0) begin
                  s.lines[i2cee_pkg::LN_SDA] = 1'b1;
                  s.lines[i2cee_pkg::LN_SCL] = 1'b1;
                  s.wait_count = 16'd1;
               end else begin
                  s.lines[i2cee_pkg::LN_SCL] = 1'b0;
                  r = 2'd1;
               end
            end
            i2cee_pkg::K_RD: begin
               if (s.wait_count == 16'd0) begin
                  s.lines[i2cee_pkg::LN_SCL] = 1'b0;
                  s.wait_count = 16'd1;
               end else if (s.wait_count == 16'd1) begin
                  s.lines[i2cee_pkg::LN_SCL] = 1'b1;
                  s.wait_count = 16'd2;
               end else if (s.wait_count == 16'd2) begin
                  s.shift_byte = {s.shift_byte[6:0], sda};
                  s.wait_count = 16'd3;
               end else begin
                  s.lines[i2cee_pkg::LN_SCL] = 1'b0;
                  s.bit_index = 4'(s.bit_index + 4'd1);
                  if (s.bit_index >= i2cee_pkg::READ_BITS) begin
                     s.captured = s.shift_byte;
                     r = 2'd1;
                  end else begin
                     s.wait_count = 16'd1;
                  end
               end
            end
            i2cee_pkg::K_WAIT: begin
               if (s.wait_count != '0) begin
                  s.wait_count = 16'(s.wait_count - 16'd1);
               end
               r = (s.wait_count == '0) ? 2'd1 : 2'd0;
            end
            i2cee_pkg::K_REC_INIT: begin
               s.lines[i2cee_pkg::LN_SDA] = 1'b1;
               r = 2'd1;
            end
            i2cee_pkg::K_REC_LOOP: begin
               if (s.wait_count == '0) begin
                  s.lines[i2cee_pkg::LN_SCL] = 1'b1;
                  s.bit_index = 4'(s.bit_index + 4'd1);
                  s.wait_count = 16'd1;
               end else begin
                  s.lines[i2cee_pkg::LN_SCL] = 1'b0;
                  if (sda) begin
                     r = 2'd2;
                  end else if (s.bit_index >= i2cee_pkg::REC_PULSES) begin
                     r = 2'd1;
                  end else begin
                     s.wait_count = 16'd0;
                  end
               end
            end
            i2cee_pkg::K_REC_TAIL: begin
               if (s.wait_count == 16'd0) begin
                  s.lines[i2cee_pkg::LN_SCL] = 1'b0;
                  s.wait_count = 16'd1;
               end else if (s.wait_count == 16'd1) begin
                  s.lines[i2cee_pkg::LN_SDA] = 1'b1;
                  s.lines[i2cee_pkg::LN_SCL] = 1'b1;
                  s.wait_count = 16'd2;
               end else begin
                  s.lines[i2cee_pkg::LN_SDA] = 1'b0;
                  r = 2'd1;
               end
            end
            default: r = 2'd1;
         endcase
         if (r != 2'd0) begin
            if (i2cee_pkg::phase_last(s.phase)) begin
               s.phase = i2cee_pkg::PH_IDLE;
               s.bit_index = '0;
               s.wait_count = '0;
               o.done = 1'b1;
            end else begin
               s = enter_phase(s, 5'(s.phase + 5'd1), wct);
               if (r == 2'd2) begin
                  s.wait_count = 16'd1;
               end
            end
         end
      end
      o.nxt = s;
      return o;
   endfunction

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      step = run_step(seq_ff, req_tuser, req_tdata[10:0], req_tdata[18:11],
                      req_tdata[19], wct_ff);
      seq_in = req_fire ? step.nxt : seq_ff;
      wct_in = (csr_valid && csr_ready) ? csr_wdata : wct_ff;
      rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_tready);
      rsp_data_in = rsp_data_ff;
      if (req_fire) begin
         rsp_data_in = {3'b0, step.nxt.captured, step.done, step.busy,
                        step.nxt.lines[i2cee_pkg::LN_WP],
                        step.nxt.lines[i2cee_pkg::LN_SDA],
                        step.nxt.lines[i2cee_pkg::LN_SCL]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= '{phase: i2cee_pkg::PH_IDLE, bit_index: '0, shift_byte: '0,
                           wait_count: '0, captured: '0, address: '0, data: '0,
                           lines: 3'b111};
         wct_ff       <= i2cee_pkg::WRITE_CYCLE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         wct_ff       <= wct_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && rsp_valid_ff && !rsp_tready))
      else $error("request taken while response stalled");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff[4] || rsp_data_ff[3]))
      else $error("done without busy");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      seq_ff.phase <= i2cee_pkg::PH_REC_END)
      else $error("phase out of range");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && step.done) |=> (seq_ff.phase == i2cee_pkg::PH_IDLE))
      else $error("sequence not idle after done");

endmodule

// ===== tb/i2c_eeprom_byte_access_master_core_test.sv =====
// Self-checking testbench for the I2C EEPROM byte access master: drives bus ticks as
// request transfers, predicts each response with a cycle-level sequencer model or a fixed row value.
// Depends on i2cee_pkg and i2c_eeprom_byte_access_master_core.
`timescale 1ns / 1ps

module i2c_eeprom_byte_access_master_core_test;
   import i2cee_pkg::*;

   localparam int LIMIT           = 1500000;
   localparam int RSP_HOLD_CYCLES = 120;
   localparam logic [3:0] BYTE_BITS = 4'd8;

   typedef struct packed {
      op_type      op;
      logic [10:0] addr;
      logic [7:0]  wdata;
      logic        sda;
   } bus_tick_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       done;
      logic       busy;
      logic       wp;
      logic       sda;
      logic       scl;
   } bus_rsp_type;

   typedef struct packed {
      logic        is_cfg;
      op_type      op;
      logic [10:0] addr;
      logic [7:0]  wdata;
      logic [6:0]  sda_pct;
      logic        typed;
      bus_rsp_type typed_rsp;
      logic [15:0] cfg;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // address[10:0], write_data[18:11], sda_in[19], zero
   logic [1:0]  req_tuser = '0;   // operation[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // scl[0], sda_drive[1], write_protect[2], busy_res[3],
                                  // done_res[4], read_data[12:5], zero
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_wdata = '0;   // write_cycle_ticks

   // sequencer model state
   logic [15:0] wait_ticks    = WRITE_CYCLE_RESET;
   logic [4:0]  seq_phase     = PH_IDLE;
   logic [3:0]  seq_bit       = '0;
   logic [7:0]  seq_shift     = '0;
   logic [15:0] seq_count     = '0;
   logic [7:0]  seq_read_byte = '0;
   logic [10:0] seq_addr      = '0;
   logic [7:0]  seq_data      = '0;
   logic        line_scl      = 1'b1;
   logic        line_sda      = 1'b1;
   logic        line_wp       = 1'b1;

   bus_rsp_type pending_lines [$];
   int       fails = 0;
   int       send_idle_pct = 0;
   int       recv_idle_pct = 0;
   int       rsp_hold_asks = 0;
   int       cycle_count = 0;

   i2c_eeprom_byte_access_master_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic kind_type kind_at(input logic [4:0] p);
      case (p)
         PH_WRITE:                                  return K_WPLOW;
         5'd2, PH_READ, 5'd17:                      return K_START;
         5'd3, 5'd13:                               return K_WR_DEVW;
         5'd4, 5'd6, 5'd8, 5'd14, 5'd16, 5'd19, 5'd21: return K_ACK;
         5'd5, 5'd15:                               return K_WR_WORD;
         5'd7:                                      return K_WR_DATA;
         5'd9, PH_RD_LAST:                          return K_STOP;
         5'd10:                                     return K_WAIT;
         PH_WR_LAST:                                return K_WPHIGH;
         5'd18:                                     return K_WR_DEVR;
         5'd20:                                     return K_RD;
         PH_RECOVER:                                return K_REC_INIT;
         5'd24:                                     return K_REC_LOOP;
         PH_REC_END:                                return K_REC_TAIL;
         default:                                   return K_IDLE;
      endcase
   endfunction

   function automatic logic [7:0] device_addr_byte();
      return DEV_BASE | {4'b0000, seq_addr[10:8], 1'b0};
   endfunction

   function automatic void begin_phase(input logic [4:0] p);
      seq_phase = p;
      seq_bit   = '0;
      seq_count = '0;
      case (kind_at(p))
         K_WR_DEVW: seq_shift = device_addr_byte() & DEV_WR_AND;
         K_WR_DEVR: seq_shift = device_addr_byte() | DEV_RD_OR;
         K_WR_WORD: seq_shift = seq_addr[7:0];
         K_WR_DATA: seq_shift = seq_data;
         K_RD:      seq_shift = '0;
         K_WAIT: begin
            seq_count = wait_ticks;
            if (wait_ticks == 16'd0) seq_phase = p + 5'd1;
         end
         default: ;
      endcase
   endfunction

   // 0 running, 1 phase finished, 2 finished with the recovery clock-low tick skipped
   function automatic int run_phase_tick(input logic sda_in);
      int r;
      r = 0;
      case (kind_at(seq_phase))
         K_WPLOW: begin
            line_wp = 1'b0;
            r = 1;
         end
         K_WPHIGH: begin
            line_wp = 1'b1;
            r = 1;
         end
         K_START: begin
            if (seq_count == 0) begin
               line_sda = 1'b1;
               line_scl = 1'b1;
               seq_count = 1;
            end else begin
               line_sda = 1'b0;
               r = 1;
            end
         end
         K_STOP: begin
            if (seq_count == 0) begin
               line_sda = 1'b0;
               line_scl = 1'b1;
               seq_count = 1;
            end else begin
               line_sda = 1'b1;
               r = 1;
            end
         end
         K_WR_DEVW, K_WR_DEVR, K_WR_WORD, K_WR_DATA: begin
            if (seq_bit >= BYTE_BITS) begin
               line_scl = 1'b0;
               line_sda = 1'b1;
               r = 1;
            end else if (seq_count == 0) begin
               line_scl = 1'b0;
               seq_count = 1;
            end else if (seq_count == 1) begin
               line_sda = seq_shift[7];
               seq_count = 2;
            end else begin
               line_scl = 1'b1;
               seq_shift = seq_shift << 1;
               seq_bit++;
               seq_count = 0;
            end
         end
         K_ACK: begin
            if (seq_count == 0) begin
               line_sda = 1'b1;
               line_scl = 1'b1;
               seq_count = 1;
            end else begin
               line_scl = 1'b0;
               r = 1;
            end
         end
         K_RD: begin
            if (seq_count == 0) begin
               line_scl = 1'b0;
               seq_count = 1;
            end else if (seq_count == 1) begin
               line_scl = 1'b1;
               seq_count = 2;
            end else if (seq_count == 2) begin
               seq_shift = {seq_shift[6:0], sda_in};
               seq_count = 3;
            end else begin
               line_scl = 1'b0;
               seq_bit++;
               if (seq_bit >= READ_BITS) begin
                  seq_read_byte = seq_shift;
                  r = 1;
               end else begin
                  seq_count = 1;
               end
            end
         end
         K_WAIT: begin
            if (seq_count != 0) seq_count--;
            if (seq_count == 0) r = 1;
         end
         K_REC_INIT: begin
            line_sda = 1'b1;
            r = 1;
         end
         K_REC_LOOP: begin
            if (seq_count == 0) begin
               line_scl = 1'b1;
               seq_bit++;
               seq_count = 1;
            end else begin
               line_scl = 1'b0;
               if (sda_in) r = 2;
               else if (seq_bit >= REC_PULSES) r = 1;
               else seq_count = 0;
            end
         end
         K_REC_TAIL: begin
            if (seq_count == 0) begin
               line_scl = 1'b0;
               seq_count = 1;
            end else if (seq_count == 1) begin
               line_sda = 1'b1;
               line_scl = 1'b1;
               seq_count = 2;
            end else begin
               line_sda = 1'b0;
               r = 1;
            end
         end
         default: r = 1;
      endcase
      return r;
   endfunction

   function automatic bus_rsp_type advance_tick(input bus_tick_type t);
      bus_rsp_type o;
      int       r;
      o = '0;
      if (kind_at(seq_phase) == K_IDLE) begin
         seq_phase = PH_IDLE;
         if (t.op != OP_NONE) begin
            seq_addr = t.addr & ADDR_MASK;
            seq_data = t.wdata;
            if (t.op == OP_READ) begin_phase(PH_READ);
            else if (t.op == OP_WRITE) begin_phase(PH_WRITE);
            else begin_phase(PH_RECOVER);
         end
      end
      if (seq_phase != PH_IDLE) begin
         o.busy = 1'b1;
         r = run_phase_tick(t.sda);
         if (r != 0) begin
            if (seq_phase == PH_WR_LAST || seq_phase == PH_RD_LAST ||
                seq_phase == PH_REC_END) begin
               seq_phase = PH_IDLE;
               seq_bit   = '0;
               seq_count = '0;
               o.done    = 1'b1;
            end else begin
               begin_phase(seq_phase + 5'd1);
               if (r == 2) seq_count = 1;
            end
         end
      end
      o.scl       = line_scl;
      o.sda       = line_sda;
      o.wp        = line_wp;
      o.read_data = seq_read_byte;
      return o;
   endfunction

   function automatic bus_rsp_type rsp_of(input logic scl, input logic sda, input logic wp,
                                          input logic busy, input logic done,
                                          input logic [7:0] rd);
      return '{read_data: rd, done: done, busy: busy, wp: wp, sda: sda, scl: scl};
   endfunction

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $display("%0t %s expected %0d got %0d", $time, name, want, got);
         fails++;
      end
   endfunction

   function automatic void check_lines(input bus_rsp_type got);
      bus_rsp_type want;
      if (pending_lines.size() == 0) begin
         $display("%0t unexpected response expected none got %h", $time, got);
         fails++;
         return;
      end
      want = pending_lines.pop_front();
      compare_field("scl", want.scl, got.scl);
      compare_field("sda_drive", want.sda, got.sda);
      compare_field("write_protect", want.wp, got.wp);
      compare_field("busy", want.busy, got.busy);
      compare_field("done", want.done, got.done);
      compare_field("read_data", want.read_data, got.read_data);
   endfunction

   // called and returning just after a falling edge
   task automatic send_tick(input bus_tick_type t, input logic typed,
                            input bus_rsp_type typed_rsp);
      bus_rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, t.sda, t.wdata, t.addr};
      req_tuser  <= t.op;
      do @(posedge clock); while (!req_tready);
      predicted = advance_tick(t);
      pending_lines.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_lines.size() != 0);
   endtask

   task automatic write_wait_ticks(input logic [15:0] v);
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      wait_ticks = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int items, input int drain_at, input int hold_at);
      bus_tick_type t;
      int        sda_pct;
      int        pick;
      sda_pct = 50;
      for (int n = 0; n < items || seq_phase != PH_IDLE; n++) begin
         if (n == drain_at) wait_drained();
         if (n == hold_at) rsp_hold_asks++;
         t.addr  = 11'($urandom);
         t.wdata = 8'($urandom);
         t.op    = op_type'(2'($urandom_range(3)));
         if (seq_phase == PH_IDLE && n < items) begin
            pick = $urandom_range(99);
            if (pick < 8) t.op = OP_NONE;
            else if (pick < 38) t.op = OP_READ;
            else if (pick < 69) t.op = OP_WRITE;
            else t.op = OP_RECOVER;
            sda_pct = 15 + 35 * $urandom_range(2);
         end
         t.sda = ($urandom_range(99) < sda_pct);
         send_tick(t, 1'b0, '0);
      end
   endtask

   // response side: check at the rising edge, drive ready at the falling edge
   initial begin
      int hold_left;
      int asks_seen;
      hold_left = 0;
      asks_seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_lines(bus_rsp_type'(rsp_tdata[12:0]));
         @(negedge clock);
         if (rsp_hold_asks != asks_seen) begin
            asks_seen = rsp_hold_asks;
            hold_left = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      dir_row_type  dir_rows [17];
      bus_tick_type t;
      dir_rows = '{
         '{1'b0, OP_NONE,    11'h000, 8'h00, 7'd0,   1'b1, rsp_of(1, 1, 1, 0, 0, 0), 16'd0},
         '{1'b0, OP_WRITE,   11'h7FF, 8'hFF, 7'd50,  1'b1, rsp_of(1, 1, 0, 1, 0, 0), 16'd0},
         '{1'b1, OP_NONE,    11'h000, 8'h00, 7'd0,   1'b0, '0,                       16'd0},
         '{1'b0, OP_WRITE,   11'h000, 8'h00, 7'd50,  1'b0, '0,                       16'd0},
         '{1'b0, OP_READ,    11'h700, 8'h00, 7'd100, 1'b1, rsp_of(1, 1, 1, 1, 0, 0), 16'd0},
         '{1'b0, OP_READ,    11'h0FF, 8'hFF, 7'd0,   1'b0, '0,                       16'd0},
         '{1'b0, OP_RECOVER, 11'h000, 8'h00, 7'd100, 1'b0, '0,                       16'd0},
         '{1'b0, OP_RECOVER, 11'h7FF, 8'hFF, 7'd0,   1'b0, '0,                       16'd0},
         '{1'b0, OP_RECOVER, 11'h2AA, 8'h55, 7'd50,  1'b0, '0,                       16'd0},
         '{1'b0, OP_NONE,    11'h555, 8'hAA, 7'd100, 1'b0, '0,                       16'd0},
         '{1'b0, OP_READ,    11'h555, 8'hAA, 7'd50,  1'b0, '0,                       16'd0},
         '{1'b1, OP_NONE,    11'h000, 8'h00, 7'd0,   1'b0, '0,                       16'd2},
         '{1'b0, OP_WRITE,   11'h123, 8'hA5, 7'd50,  1'b0, '0,                       16'd0},
         '{1'b1, OP_NONE,    11'h000, 8'h00, 7'd0,   1'b0, '0,                       16'd1},
         '{1'b0, OP_WRITE,   11'h400, 8'h5A, 7'd50,  1'b0, '0,                       16'd0},
         '{1'b1, OP_NONE,    11'h000, 8'h00, 7'd0,   1'b0, '0,                       16'd400},
         '{1'b0, OP_READ,    11'h2AA, 8'h00, 7'd50,  1'b0, '0,                       16'd0}
      };
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 26;
      recv_idle_pct = 46;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            write_wait_ticks(dir_rows[i].cfg);
         end else begin
            t.op    = dir_rows[i].op;
            t.addr  = dir_rows[i].addr;
            t.wdata = dir_rows[i].wdata;
            t.sda   = ($urandom_range(99) < dir_rows[i].sda_pct);
            send_tick(t, dir_rows[i].typed, dir_rows[i].typed_rsp);
            // hold the line pattern of the row; commands while busy must be ignored
            while (seq_phase != PH_IDLE) begin
               t.op    = op_type'(2'($urandom_range(3)));
               t.addr  = 11'($urandom);
               t.wdata = 8'($urandom);
               t.sda   = ($urandom_range(99) < dir_rows[i].sda_pct);
               send_tick(t, 1'b0, '0);
            end
         end
      end

      write_wait_ticks(16'($urandom_range(1, 40)));
      run_random(70, -1, -1);

      send_idle_pct = 46;
      recv_idle_pct = 26;
      write_wait_ticks(16'($urandom_range(0, 8)));
      run_random(70, 35, -1);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_wait_ticks(16'($urandom_range(2, 20)));
      run_random(80, -1, 30);

      wait_drained();
      repeat (8) @(posedge clock);
      if (fails == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
